[hdl/rsvm_pkg.sv]
// ----------------------------------------------------------------------------
// rsvm_pkg: shared types and codes for the register/stack VM execute block
// Opcodes, status codes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package rsvm_pkg;

	localparam int unsigned WORD_W = 64;

	typedef enum logic [4:0] {
		OP_MOV    = 5'd0,
		OP_MOVIMM = 5'd1,
		OP_ADD    = 5'd2,
		OP_ADDIMM = 5'd3,
		OP_SUB    = 5'd4,
		OP_MUL    = 5'd5,
		OP_DIV    = 5'd6,
		OP_MOD    = 5'd7,
		OP_LT     = 5'd8,
		OP_LE     = 5'd9,
		OP_EQ     = 5'd10,
		OP_NE     = 5'd11,
		OP_GE     = 5'd12,
		OP_GT     = 5'd13,
		OP_STORE  = 5'd14,
		OP_LOAD   = 5'd15,
		OP_JMP    = 5'd16,
		OP_JZ     = 5'd17,
		OP_CALL   = 5'd18,
		OP_RET    = 5'd19,
		OP_PUSH   = 5'd20,
		OP_POP    = 5'd21,
		OP_PRINT  = 5'd22,
		OP_EXIT   = 5'd23
	} opcode_t;

	typedef enum logic [2:0] {
		ST_RUN   = 3'd0,
		ST_EXIT  = 3'd1,
		ST_END   = 3'd2,
		ST_BADOP = 3'd3,
		ST_OVER  = 3'd4,
		ST_UNDER = 3'd5,
		ST_DIVZ  = 3'd6,
		ST_RANGE = 3'd7
	} status_t;

	// Instruction as classified by the front end.
	typedef struct packed {
		logic [4:0]        opcode;
		logic              bad_op;
		logic              is_div;
		logic [4:0]        dst_reg;
		logic [4:0]        src_reg;
		logic [WORD_W-1:0] immediate;
		logic [15:0]       target;
	} instr_t;

endpackage

[hdl/rsvm_front.sv]
// ----------------------------------------------------------------------------
// rsvm_front: instruction intake and classification
// Takes input beats into a two-entry queue and tags each instruction.
// ----------------------------------------------------------------------------
module rsvm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         opcode,
	input  logic [4:0]         dst_reg,
	input  logic [4:0]         src_reg,
	input  logic [63:0]        immediate,
	input  logic [15:0]        target,
	output logic               q_valid,
	output rsvm_pkg::instr_t   q_instr,
	input  logic               q_take
);

	rsvm_pkg::instr_t ent_q [2];
	logic             rd_ptr_q, wr_ptr_q;
	logic [1:0]       cnt_q;
	logic             push, pop;
	rsvm_pkg::instr_t cls;

	always_comb begin
		cls.opcode    = opcode;
		cls.bad_op    = (opcode > rsvm_pkg::OP_EXIT);
		cls.is_div    = (opcode == rsvm_pkg::OP_DIV) || (opcode == rsvm_pkg::OP_MOD);
		cls.dst_reg   = dst_reg;
		cls.src_reg   = src_reg;
		cls.immediate = immediate;
		cls.target    = target;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_take;
	assign q_instr  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd2) |-> !push)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");

endmodule

[hdl/rsvm_divider.sv]
// ----------------------------------------------------------------------------
// rsvm_divider: radix-2 restoring divider, unsigned 64-bit
// One quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module rsvm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);

	logic [63:0] quo_q, rem_q, dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted   = {rem_q, quo_q[63]};
	assign trial     = shifted - {1'b0, dvs_q};
	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = busy_q && (cnt_q == 7'd0);

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q && cnt_q != 7'd0) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 7'd1;
		end
	end

endmodule

[hdl/rsvm_back.sv]
// ----------------------------------------------------------------------------
// rsvm_back: execute stage
// Register file, stack memory and instruction pointer; one result per beat.
// ----------------------------------------------------------------------------
module rsvm_back #(
	parameter int unsigned STACK_DEPTH = 1024,
	parameter int unsigned REG_COUNT   = 32,
	parameter int unsigned IP_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        program_length,
	input  logic               q_valid,
	input  rsvm_pkg::instr_t   q_instr,
	output logic               q_take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        next_ip,
	output logic [2:0]         status,
	output logic signed [63:0] exit_value,
	output logic               print_valid,
	output logic [63:0]        print_value
);

	localparam int unsigned RB = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int unsigned SB = $clog2(STACK_DEPTH);
	localparam logic [64:0] DEPTH65 = 65'(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_MUL, S_WAIT
	} state_t;

	state_t             state_q;
	rsvm_pkg::instr_t   ins_q;
	logic [63:0]        regs_q [REG_COUNT];
	logic [REG_COUNT-1:0] rvalid_q;
	logic [63:0]        stk_q [STACK_DEPTH];
	logic [SB-1:0]      clr_q;
	logic [IP_BITS-1:0] ip_q;
	logic [63:0]        sdata_q;
	logic [63:0]        sp_q, a_q, b_q;

	logic [RB-1:0]      d_idx, s_idx, two_idx;
	logic [63:0]        rf_bp, rf_sp, rf_a, rf_b;
	logic [64:0]        ld_addr, st_addr;
	logic               ld_ok, st_ok;
	logic [SB-1:0]      rd_addr;
	logic [63:0]        stop;
	logic               div_start, div_done;
	logic [63:0]        quo, rem;

	// multiply: three 32x32 products, one per cycle
	logic               mul_start;
	logic [1:0]         mstep_q;
	logic [63:0]        prod_q;
	logic [31:0]        mx, my;
	logic [63:0]        pp;

	// execute results
	logic               wr_reg, wr_sp, wr_stk;
	logic [RB-1:0]      wr_idx;
	logic [63:0]        wr_val, stk_val;
	logic [SB-1:0]      stk_addr;
	logic [IP_BITS-1:0] nxt;
	logic [2:0]         st;
	logic [63:0]        exv, pv;
	logic               pvl;
	logic [IP_BITS-1:0] ip_inc, tgt;

	// reduce a register number by conditional subtraction
	function automatic logic [RB-1:0] reg_of(input logic [4:0] r);
		logic [5:0] m;
		m = {1'b0, r};
		for (int k = 0; k < 8; k++)
			if (m >= 6'(REG_COUNT)) m = m - 6'(REG_COUNT);
		return m[RB-1:0];
	endfunction

	function automatic logic [63:0] rd_reg(input logic [63:0] v, input logic ok);
		return ok ? v : 64'd0;
	endfunction

	assign d_idx   = reg_of(ins_q.dst_reg);
	assign s_idx   = reg_of(ins_q.src_reg);
	assign two_idx = reg_of(5'd2);
	assign rf_bp   = rd_reg(regs_q[0], rvalid_q[0]);
	assign rf_sp   = rd_reg(regs_q[1], rvalid_q[1]);
	assign rf_a    = rd_reg(regs_q[d_idx], rvalid_q[d_idx]);
	assign rf_b    = rd_reg(regs_q[s_idx], rvalid_q[s_idx]);

	assign st_addr = {1'b0, rf_bp} + {60'd0, ins_q.dst_reg};
	assign ld_addr = {1'b0, rf_bp} + {60'd0, ins_q.src_reg};
	assign st_ok   = (rf_bp < 64'(STACK_DEPTH)) && (st_addr < DEPTH65);
	assign ld_ok   = (rf_bp < 64'(STACK_DEPTH)) && (ld_addr < DEPTH65);

	// stack read address: load slot or top of stack
	always_comb begin
		if (ins_q.opcode == rsvm_pkg::OP_LOAD) rd_addr = ld_addr[SB-1:0];
		else rd_addr = SB'(rf_sp - 64'd1);
	end

	// low half times low half, then the two cross terms
	always_comb begin
		case (mstep_q)
			2'd0: begin mx = a_q[31:0];  my = b_q[31:0];  end
			2'd1: begin mx = a_q[31:0];  my = b_q[63:32]; end
			default: begin mx = a_q[63:32]; my = b_q[31:0]; end
		endcase
	end

	assign pp        = 64'(mx) * 64'(my);
	assign stop      = sdata_q;
	assign div_start = (state_q == S_EXEC) && ins_q.is_div && (b_q != 64'd0);
	assign mul_start = (state_q == S_EXEC) && (ins_q.opcode == rsvm_pkg::OP_MUL);
	assign q_take    = (state_q == S_IDLE) && q_valid;
	assign ip_inc    = ip_q + IP_BITS'(1);
	assign tgt       = IP_BITS'(ins_q.target);

	rsvm_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a_q),
		.divisor   (b_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_comb begin
		wr_reg   = 1'b0;
		wr_sp    = 1'b0;
		wr_stk   = 1'b0;
		wr_idx   = d_idx;
		wr_val   = 64'd0;
		stk_val  = b_q;
		stk_addr = SB'(sp_q);
		nxt      = ip_inc;
		st       = rsvm_pkg::ST_RUN;
		exv      = 64'd0;
		pv       = 64'd0;
		pvl      = 1'b0;
		if (32'(ip_q) >= 32'(program_length)) begin
			nxt = ip_q;
			st  = rsvm_pkg::ST_END;
		end else begin
			case (ins_q.opcode)
				rsvm_pkg::OP_MOV:    begin wr_reg = 1'b1; wr_val = b_q; end
				rsvm_pkg::OP_MOVIMM: begin wr_reg = 1'b1; wr_val = ins_q.immediate; end
				rsvm_pkg::OP_ADD:    begin wr_reg = 1'b1; wr_val = a_q + b_q; end
				rsvm_pkg::OP_ADDIMM: begin wr_reg = 1'b1; wr_val = a_q + ins_q.immediate; end
				rsvm_pkg::OP_SUB:    begin wr_reg = 1'b1; wr_val = a_q - b_q; end
				rsvm_pkg::OP_MUL: begin
					wr_reg = 1'b1;
					wr_val = prod_q + {pp[31:0], 32'd0};
				end
				rsvm_pkg::OP_DIV, rsvm_pkg::OP_MOD: begin
					if (b_q == 64'd0) st = rsvm_pkg::ST_DIVZ;
					else begin
						wr_reg = 1'b1;
						wr_val = (ins_q.opcode == rsvm_pkg::OP_DIV) ? quo : rem;
					end
				end
				rsvm_pkg::OP_LT: begin wr_reg = 1'b1; wr_val = {63'd0, a_q < b_q}; end
				rsvm_pkg::OP_LE: begin wr_reg = 1'b1; wr_val = {63'd0, a_q <= b_q}; end
				rsvm_pkg::OP_EQ: begin wr_reg = 1'b1; wr_val = {63'd0, a_q == b_q}; end
				rsvm_pkg::OP_NE: begin wr_reg = 1'b1; wr_val = {63'd0, a_q != b_q}; end
				rsvm_pkg::OP_GE: begin wr_reg = 1'b1; wr_val = {63'd0, a_q >= b_q}; end
				rsvm_pkg::OP_GT: begin wr_reg = 1'b1; wr_val = {63'd0, a_q > b_q}; end
				rsvm_pkg::OP_STORE: begin
					if (!st_ok) st = rsvm_pkg::ST_RANGE;
					else begin wr_stk = 1'b1; stk_addr = st_addr[SB-1:0]; end
				end
				rsvm_pkg::OP_LOAD: begin
					if (!ld_ok) st = rsvm_pkg::ST_RANGE;
					else begin wr_reg = 1'b1; wr_val = stop; end
				end
				rsvm_pkg::OP_JMP: nxt = tgt;
				rsvm_pkg::OP_JZ:  if (b_q == 64'd0) nxt = tgt;
				rsvm_pkg::OP_CALL, rsvm_pkg::OP_PUSH: begin
					if (sp_q >= 64'(STACK_DEPTH)) st = rsvm_pkg::ST_OVER;
					else begin
						wr_stk = 1'b1;
						wr_sp  = 1'b1;
						if (ins_q.opcode == rsvm_pkg::OP_CALL) begin
							stk_val = 64'(ip_inc);
							nxt     = tgt;
						end
					end
				end
				rsvm_pkg::OP_RET, rsvm_pkg::OP_POP, rsvm_pkg::OP_PRINT: begin
					if (sp_q == 64'd0) st = rsvm_pkg::ST_UNDER;
					else if (sp_q > 64'(STACK_DEPTH)) st = rsvm_pkg::ST_RANGE;
					else if (ins_q.opcode == rsvm_pkg::OP_RET) begin
						wr_sp = 1'b1;
						nxt   = stop[IP_BITS-1:0];
					end else if (ins_q.opcode == rsvm_pkg::OP_POP) begin
						wr_sp  = 1'b1;
						wr_reg = 1'b1;
						wr_val = stop;
					end else begin
						pvl = 1'b1;
						pv  = stop;
					end
				end
				rsvm_pkg::OP_EXIT: begin
					st  = rsvm_pkg::ST_EXIT;
					exv = rd_reg(regs_q[two_idx], rvalid_q[two_idx]);
				end
				default: begin
					st  = rsvm_pkg::ST_BADOP;
					exv = 64'd1;
				end
			endcase
			if (st != rsvm_pkg::ST_RUN) begin
				nxt    = ip_q;
				wr_reg = 1'b0;
				wr_sp  = 1'b0;
				wr_stk = 1'b0;
			end else if (32'(nxt) >= 32'(program_length)) begin
				st = rsvm_pkg::ST_END;
			end
		end
	end

	logic commit;
	logic sp_only;
	assign commit = ((state_q == S_EXEC) && !div_start && !mul_start) ||
		((state_q == S_DIV) && div_done) || ((state_q == S_MUL) && (mstep_q == 2'd2));
	// a pop into the stack pointer itself keeps the popped word
	assign sp_only = wr_sp && !(wr_reg && (wr_idx == RB'(1)));

	// stack memory: registered read, one write port shared with the clearing pass
	always_ff @(posedge clk) begin
		if (state_q == S_READ) sdata_q <= stk_q[rd_addr];
		if (state_q == S_CLEAR) stk_q[clr_q] <= 64'd0;
		else if (commit && wr_stk) stk_q[stk_addr] <= stk_val;
	end

	always_ff @(posedge clk) begin
		if (q_take) ins_q <= q_instr;
		if (state_q == S_READ) begin
			sp_q <= rf_sp;
			a_q  <= rf_a;
			b_q  <= rf_b;
		end
		if (mul_start) prod_q <= pp;
		else if (state_q == S_MUL && mstep_q == 2'd1) prod_q <= prod_q + {pp[31:0], 32'd0};
		if (commit) begin
			if (sp_only) regs_q[1] <= (wr_stk ? sp_q + 64'd1 : sp_q - 64'd1);
			if (wr_reg) regs_q[wr_idx] <= wr_val;
			next_ip     <= 16'(nxt);
			status      <= st;
			exit_value  <= exv;
			print_valid <= pvl;
			print_value <= pv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			mstep_q   <= 2'd0;
			rvalid_q  <= '0;
			ip_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (mul_start) mstep_q <= 2'd1;
			else if (state_q == S_MUL) mstep_q <= (mstep_q == 2'd2) ? 2'd0 : mstep_q + 2'd1;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SB'(1);
					if (clr_q == SB'(STACK_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (q_take) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC, S_DIV, S_MUL: if (commit) begin
					if (sp_only) rvalid_q[1] <= 1'b1;
					if (wr_reg) rvalid_q[wr_idx] <= 1'b1;
					if (st == rsvm_pkg::ST_RUN || st == rsvm_pkg::ST_END) begin
						if (32'(ip_q) < 32'(program_length)) ip_q <= nxt;
					end
					out_valid <= 1'b1;
					state_q   <= S_WAIT;
				end else if (mul_start) state_q <= S_MUL;
				else if (div_start) state_q <= S_DIV;
				S_WAIT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> (state_q == S_WAIT))
		else $error("result shown outside wait state");
	assert property (@(posedge clk) disable iff (!arst_n) div_start |=> (state_q == S_DIV))
		else $error("divide started but not waited for");
	assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid && out_stall) |=> $stable(next_ip) && $stable(status))
		else $error("stalled result changed");

endmodule

[hdl/register_stack_vm_execute.sv]
// ----------------------------------------------------------------------------
// register_stack_vm_execute: bytecode execute block of a 64-bit VM
// Front queue classifies instructions; back end executes them in order.
// ----------------------------------------------------------------------------
// Each input beat is one instruction at the current instruction pointer; each
// yields exactly one result beat (next_ip, status, exit_value, print fields).
// An instruction passes through dequeue, register and stack read, execute and
// the result beat, which is held while out_stall is high. Multiply adds steps
// for its three 32x32 partial products, and divide and modulo by a nonzero
// divisor wait for the one-bit-per-cycle divider. The front queue holds two
// beats so the source can keep feeding while the back works. Registers read
// as zero after reset through per-register valid bits; the stack is cleared
// by a pass over all STACK_DEPTH words (1024 by default) right after reset,
// during which beats wait in the queue and in_stall rises once it is full.
// The user writes program_length only while idle; the block does not check.
module register_stack_vm_execute #(
	parameter int unsigned STACK_DEPTH = 1024,
	parameter int unsigned REG_COUNT   = 32,
	parameter int unsigned IP_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         opcode,
	input  logic [4:0]         dst_reg,
	input  logic [4:0]         src_reg,
	input  logic [63:0]        immediate,
	input  logic [15:0]        target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        next_ip,
	output logic [2:0]         status,
	output logic signed [63:0] exit_value,
	output logic               print_valid,
	output logic [63:0]        print_value
);

	logic [15:0]      prog_len_q;
	logic             q_valid, q_take;
	rsvm_pkg::instr_t q_instr;

	// hold the program length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prog_len_q <= 16'd0;
		else if (cfg_we) prog_len_q <= cfg_wdata;
	end

	rsvm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.dst_reg   (dst_reg),
		.src_reg   (src_reg),
		.immediate (immediate),
		.target    (target),
		.q_valid   (q_valid),
		.q_instr   (q_instr),
		.q_take    (q_take)
	);

	rsvm_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.REG_COUNT   (REG_COUNT),
		.IP_BITS     (IP_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.program_length (prog_len_q),
		.q_valid        (q_valid),
		.q_instr        (q_instr),
		.q_take         (q_take),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_ip        (next_ip),
		.status         (status),
		.exit_value     (exit_value),
		.print_valid    (print_valid),
		.print_value    (print_value)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for register_stack_vm_execute
// Drives random and directed instructions through the valid/stall channels,
// predicts every result beat from a model of the VM state, and compares.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic [15:0] next_ip;
		logic [2:0]  status;
		logic [63:0] exit_value;
		logic        print_valid;
		logic [63:0] print_value;
	} vm_result_t;

	// VM state model and the queue of results it has predicted.
	class vm_scoreboard;
		logic [63:0] regs [32];
		logic [63:0] stack_words [1024];
		logic [15:0] ip;
		logic [15:0] prog_len;
		vm_result_t  pending_results [$];
		int          mismatches;

		function void clear();
			foreach (regs[i]) regs[i] = '0;
			foreach (stack_words[i]) stack_words[i] = '0;
			ip = '0;
			prog_len = '0;
			mismatches = 0;
		endfunction

		function bit slot_ok(logic [63:0] base, logic [63:0] off);
			return base < 64'd1024 && off < 64'd1024 - base;
		endfunction

		function rsvm_pkg::status_t top_status(logic [63:0] sp);
			if (sp == 64'd0)
				return rsvm_pkg::ST_UNDER;
			if (sp > 64'd1024)
				return rsvm_pkg::ST_RANGE;
			return rsvm_pkg::ST_RUN;
		endfunction

		// Execute one accepted instruction beat against the model.
		function void note_instruction(logic [4:0] op, logic [4:0] d, logic [4:0] s,
			logic [63:0] imm, logic [15:0] tgt);
			vm_result_t         r;
			logic [15:0]        nxt;
			logic [63:0]        a, b, bp, sp;
			rsvm_pkg::status_t  st;
			r = '0;
			nxt = ip;
			st = rsvm_pkg::ST_END;
			if (ip < prog_len) begin
				a = regs[d];
				b = regs[s];
				bp = regs[0];
				sp = regs[1];
				st = rsvm_pkg::ST_RUN;
				nxt = ip + 16'd1;
				case (rsvm_pkg::opcode_t'(op))
					rsvm_pkg::OP_MOV:    regs[d] = b;
					rsvm_pkg::OP_MOVIMM: regs[d] = imm;
					rsvm_pkg::OP_ADD:    regs[d] = a + b;
					rsvm_pkg::OP_ADDIMM: regs[d] = a + imm;
					rsvm_pkg::OP_SUB:    regs[d] = a - b;
					rsvm_pkg::OP_MUL:    regs[d] = a * b;
					rsvm_pkg::OP_DIV: begin
						if (b == 64'd0) st = rsvm_pkg::ST_DIVZ;
						else regs[d] = a / b;
					end
					rsvm_pkg::OP_MOD: begin
						if (b == 64'd0) st = rsvm_pkg::ST_DIVZ;
						else regs[d] = a % b;
					end
					rsvm_pkg::OP_LT: regs[d] = (a < b) ? 64'd1 : 64'd0;
					rsvm_pkg::OP_LE: regs[d] = (a <= b) ? 64'd1 : 64'd0;
					rsvm_pkg::OP_EQ: regs[d] = (a == b) ? 64'd1 : 64'd0;
					rsvm_pkg::OP_NE: regs[d] = (a != b) ? 64'd1 : 64'd0;
					rsvm_pkg::OP_GE: regs[d] = (a >= b) ? 64'd1 : 64'd0;
					rsvm_pkg::OP_GT: regs[d] = (a > b) ? 64'd1 : 64'd0;
					rsvm_pkg::OP_STORE: begin
						if (!slot_ok(bp, 64'(d))) st = rsvm_pkg::ST_RANGE;
						else stack_words[bp + 64'(d)] = b;
					end
					rsvm_pkg::OP_LOAD: begin
						if (!slot_ok(bp, 64'(s))) st = rsvm_pkg::ST_RANGE;
						else regs[d] = stack_words[bp + 64'(s)];
					end
					rsvm_pkg::OP_JMP: nxt = tgt;
					rsvm_pkg::OP_JZ: if (b == 64'd0) nxt = tgt;
					rsvm_pkg::OP_CALL: begin
						if (sp >= 64'd1024) st = rsvm_pkg::ST_OVER;
						else begin
							stack_words[sp] = {48'd0, nxt};
							regs[1] = sp + 64'd1;
							nxt = tgt;
						end
					end
					rsvm_pkg::OP_RET: begin
						st = top_status(sp);
						if (st == rsvm_pkg::ST_RUN) begin
							regs[1] = sp - 64'd1;
							nxt = stack_words[sp - 64'd1][15:0];
						end
					end
					rsvm_pkg::OP_PUSH: begin
						if (sp >= 64'd1024) st = rsvm_pkg::ST_OVER;
						else begin
							stack_words[sp] = b;
							regs[1] = sp + 64'd1;
						end
					end
					rsvm_pkg::OP_POP: begin
						st = top_status(sp);
						if (st == rsvm_pkg::ST_RUN) begin
							regs[1] = sp - 64'd1;
							regs[d] = stack_words[sp - 64'd1];
						end
					end
					rsvm_pkg::OP_PRINT: begin
						st = top_status(sp);
						if (st == rsvm_pkg::ST_RUN) begin
							r.print_valid = 1'b1;
							r.print_value = stack_words[sp - 64'd1];
						end
					end
					rsvm_pkg::OP_EXIT: begin
						st = rsvm_pkg::ST_EXIT;
						r.exit_value = regs[2];
					end
					default: begin
						st = rsvm_pkg::ST_BADOP;
						r.exit_value = 64'd1;
					end
				endcase
				if (st == rsvm_pkg::ST_RUN) begin
					ip = nxt;
					if (nxt >= prog_len)
						st = rsvm_pkg::ST_END;
				end else begin
					nxt = ip;
				end
			end
			r.next_ip = nxt;
			r.status = st;
			pending_results.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_result(vm_result_t got);
			vm_result_t want;
			if (pending_results.size() == 0) begin
				report("unexpected result beat", 64'(got.next_ip), 64'd0);
				return;
			end
			want = pending_results.pop_front();
			if (got.next_ip !== want.next_ip)
				report("next_ip", 64'(got.next_ip), 64'(want.next_ip));
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			if (got.exit_value !== want.exit_value)
				report("exit_value", got.exit_value, want.exit_value);
			if (got.print_valid !== want.print_valid)
				report("print_valid", 64'(got.print_valid), 64'(want.print_valid));
			if (got.print_value !== want.print_value)
				report("print_value", got.print_value, want.print_value);
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [4:0]         opcode;
	logic [4:0]         dst_reg;
	logic [4:0]         src_reg;
	logic [63:0]        immediate;
	logic [15:0]        target;
	logic               out_valid;
	logic               out_stall;
	logic [15:0]        next_ip;
	logic [2:0]         status;
	logic signed [63:0] exit_value;
	logic               print_valid;
	logic [63:0]        print_value;

	vm_scoreboard vm_sb;
	bit           no_idle;   // phase flag: both sides run flat out

	register_stack_vm_execute uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .dst_reg(dst_reg),
		.src_reg(src_reg), .immediate(immediate), .target(target),
		.out_valid(out_valid), .out_stall(out_stall), .next_ip(next_ip),
		.status(status), .exit_value(exit_value), .print_valid(print_valid),
		.print_value(print_value)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Mostly short gaps, now and then a long one.
	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: stall in bursts; accept and check on every handshake edge.
	int stall_left, run_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			run_left = 0;
		end else begin
			if (out_valid && !out_stall)
				vm_sb.check_result('{next_ip, status, exit_value, print_valid, print_value});
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				out_stall <= 1'b0;
			end else begin
				// pick the next stall burst and the free run after it
				stall_left = gap_len();
				run_left = $urandom_range(0, 6);
				out_stall <= (stall_left > 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	// Hold the beat until it is taken, then note it in the model.
	task send_instr(logic [4:0] op, logic [4:0] d, logic [4:0] s, logic [63:0] imm,
		logic [15:0] tgt);
		int g;
		in_valid <= 1'b1;
		opcode <= op;
		dst_reg <= d;
		src_reg <= s;
		immediate <= imm;
		target <= tgt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		vm_sb.note_instruction(op, d, s, imm, tgt);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drain outstanding results, settle, then write program_length.
	task set_length(logic [15:0] len);
		in_valid <= 1'b0;
		@(posedge clk);
		while (vm_sb.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		vm_sb.prog_len = len;
	endtask

	function logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Random instruction: mostly well-formed, bp set to zero or near the stack end and sp sane.
	task send_random();
		logic [4:0]  op, d, s;
		logic [63:0] imm;
		logic [15:0] tgt;
		int p;
		p = $urandom_range(0, 99);
		op = (p < 6) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
		d = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 1))
			: 5'($urandom_range(2, 31));
		s = 5'($urandom_range(0, 31));
		imm = ($urandom_range(0, 3) == 0) ? rand_word() : 64'($urandom_range(0, 40));
		if (vm_sb.prog_len != 16'd0 && $urandom_range(0, 9) != 0)
			tgt = 16'($urandom_range(0, 32'(vm_sb.prog_len - 16'd1)));
		else
			tgt = 16'($urandom());
		if (p >= 96) begin
			// repair: put sp back into a useful range
			op = rsvm_pkg::OP_MOVIMM;
			d = 5'd1;
			imm = ($urandom_range(0, 3) == 0) ? 64'd1020 + 64'($urandom_range(0, 8))
				: 64'($urandom_range(0, 12));
		end else if (p >= 93) begin
			op = rsvm_pkg::OP_MOVIMM;
			d = 5'd0;
			imm = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(990, 1030)) : 64'd0;
		end
		send_instr(op, d, s, imm, tgt);
	endtask

	initial begin
		#5ms;
		$display("register_stack_vm_execute verification failed");
		$finish;
	end

	initial begin
		vm_sb = new();
		vm_sb.clear();
		no_idle = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = '0;
		dst_reg = '0;
		src_reg = '0;
		immediate = '0;
		target = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero length: nothing executes.
		send_instr(rsvm_pkg::OP_MOVIMM, 5'd2, 5'd0, 64'd5, 16'd0);
		set_length(16'hFFFF);

		// Directed: every operation but MOV and each error path.
		send_instr(rsvm_pkg::OP_MOVIMM, 5'd2, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
		send_instr(rsvm_pkg::OP_MOVIMM, 5'd4, 5'd0, 64'd7, 16'd0);
		send_instr(rsvm_pkg::OP_ADD, 5'd5, 5'd2, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_ADDIMM, 5'd5, 5'd0, 64'h8000_0000_0000_0001, 16'd0);
		send_instr(rsvm_pkg::OP_SUB, 5'd6, 5'd4, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_MUL, 5'd2, 5'd4, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_DIV, 5'd2, 5'd3, 64'd0, 16'd0);   // divide by zero
		send_instr(rsvm_pkg::OP_MOD, 5'd2, 5'd3, 64'd0, 16'd0);   // modulo by zero
		send_instr(rsvm_pkg::OP_DIV, 5'd2, 5'd4, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_MOD, 5'd5, 5'd4, 64'd0, 16'd0);
		for (int c = rsvm_pkg::OP_LT; c <= rsvm_pkg::OP_GT; c++)
			send_instr(5'(c), 5'd7 + c[4:0], 5'd4, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_STORE, 5'd31, 5'd2, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_LOAD, 5'd8, 5'd31, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_MOVIMM, 5'd0, 5'd0, 64'd1023, 16'd0);
		send_instr(rsvm_pkg::OP_STORE, 5'd5, 5'd2, 64'd0, 16'd0);   // off the stack end
		send_instr(rsvm_pkg::OP_MOVIMM, 5'd0, 5'd0, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_PRINT, 5'd0, 5'd0, 64'd0, 16'd0);   // empty stack
		send_instr(rsvm_pkg::OP_PUSH, 5'd0, 5'd2, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_PRINT, 5'd0, 5'd0, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_CALL, 5'd0, 5'd0, 64'd0, 16'd300);
		send_instr(rsvm_pkg::OP_RET, 5'd0, 5'd0, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_POP, 5'd9, 5'd0, 64'd0, 16'd0);
		send_instr(rsvm_pkg::OP_POP, 5'd9, 5'd0, 64'd0, 16'd0);     // underflow
		send_instr(rsvm_pkg::OP_JZ, 5'd0, 5'd3, 64'd0, 16'd500);
		send_instr(rsvm_pkg::OP_JMP, 5'd0, 5'd0, 64'd0, 16'd100);
		send_instr(rsvm_pkg::OP_MOVIMM, 5'd1, 5'd0, 64'd2000, 16'd0);
		send_instr(rsvm_pkg::OP_POP, 5'd9, 5'd0, 64'd0, 16'd0);     // sp beyond the stack
		send_instr(rsvm_pkg::OP_PUSH, 5'd0, 5'd2, 64'd0, 16'd0);    // overflow
		send_instr(rsvm_pkg::OP_EXIT, 5'd0, 5'd0, 64'd0, 16'd0);
		send_instr(5'd31, 5'd31, 5'd31, 64'd0, 16'hFFFF);
		send_instr(rsvm_pkg::OP_MOVIMM, 5'd1, 5'd0, 64'd0, 16'd0);

		// Random phases over several program lengths.
		repeat (220) send_random();
		no_idle = 1'b1;
		repeat (60) send_random();
		no_idle = 1'b0;
		set_length(16'd40);
		send_instr(rsvm_pkg::OP_JMP, 5'd0, 5'd0, 64'd0, 16'd0);
		repeat (80) send_random();
		set_length(16'd0);
		repeat (5) send_random();
		set_length(16'($urandom_range(200, 60000)));
		send_instr(rsvm_pkg::OP_JMP, 5'd0, 5'd0, 64'd0, 16'd1);
		repeat (100) send_random();
		set_length(16'hFFFF);
		send_instr(rsvm_pkg::OP_JMP, 5'd0, 5'd0, 64'd0, 16'd7);
		repeat (140) send_random();

		in_valid <= 1'b0;
		@(posedge clk);
		while (vm_sb.pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (vm_sb.mismatches == 0 && vm_sb.pending_results.size() == 0)
			$display("register_stack_vm_execute verification clean");
		else
			$display("register_stack_vm_execute verification failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/rsvm_pkg.sv
hdl/rsvm_front.sv
hdl/rsvm_divider.sv
hdl/rsvm_back.sv
hdl/register_stack_vm_execute.sv
tb/testbench.sv
